### hw/rtl/dgvr_pkg.sv
// Package: shared types, codes and register reset values for the velocity ramp.
`timescale 1ns / 1ps

package dgvr_pkg;

    localparam int SPEED_W = 16;
    localparam int MAX_W   = 15;
    localparam int RATE_W  = 16;
    localparam int DT_W    = 16;
    localparam int KEYS_N  = 5;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [1:0] REQ_TICK    = 2'd0;
    localparam logic [1:0] REQ_KEY     = 2'd1;
    localparam logic [1:0] REQ_FOCUS   = 2'd2;
    localparam logic [1:0] REQ_RELEASE = 2'd3;

    localparam logic [2:0] KEY_FWD     = 3'd0;
    localparam logic [2:0] KEY_BACK    = 3'd1;
    localparam logic [2:0] KEY_LEFT    = 3'd2;
    localparam logic [2:0] KEY_RIGHT   = 3'd3;
    localparam logic [2:0] KEY_DEADMAN = 3'd4;

    localparam logic [2:0] REG_MAX_LINEAR   = 3'd0;
    localparam logic [2:0] REG_MAX_ANGULAR  = 3'd1;
    localparam logic [2:0] REG_ACCEL_RATE   = 3'd2;
    localparam logic [2:0] REG_DECEL_RATE   = 3'd3;
    localparam logic [2:0] REG_TURN_RATE    = 3'd4;
    localparam logic [2:0] REG_NEED_DEADMAN = 3'd5;
    localparam logic [2:0] REG_MAX_TICK     = 3'd6;

    localparam logic [MAX_W-1:0]  RST_MAX_LINEAR  = 15'd2048;
    localparam logic [MAX_W-1:0]  RST_MAX_ANGULAR = 15'd4096;
    localparam logic [RATE_W-1:0] RST_ACCEL_RATE  = 16'd2048;
    localparam logic [RATE_W-1:0] RST_DECEL_RATE  = 16'd4096;
    localparam logic [RATE_W-1:0] RST_TURN_RATE   = 16'd8192;
    localparam logic              RST_NEED_DEADMAN = 1'b1;
    localparam logic [DT_W-1:0]   RST_MAX_TICK    = 16'd6554;

    typedef struct packed {
        logic [1:0]      req_type;
        logic [2:0]      key_index;
        logic            level;
        logic [DT_W-1:0] dt_frac;
    } req_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] linear_cmd;
        logic signed [SPEED_W-1:0] angular_cmd;
        logic                      armed;
    } cmd_t;

endpackage

### hw/rtl/deadman_gated_velocity_ramp.sv
// Top level: config registers, request stage, key/focus state and command register.
`timescale 1ns / 1ps

// Takes one request per cycle unless req_stall is high. A request is registered,
// then key, focus and release requests update the held-key state and produce no
// command, while a tick request, once the output register is free, steps both speeds
// and loads one command into the output register. Each axis does one 16x16 multiply
// and a slew compare for a tick. A held command stalls a tick request in the request
// stage and the requests behind it; the stage frees as soon as its item moves.
module deadman_gated_velocity_ramp
    import dgvr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  req_t              req_data,
    output logic              cmd_valid,
    input  logic              cmd_stall,
    output cmd_t              cmd_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [MAX_W-1:0]  max_linear_reg;
    logic [MAX_W-1:0]  max_angular_reg;
    logic [RATE_W-1:0] accel_rate_reg;
    logic [RATE_W-1:0] decel_rate_reg;
    logic [RATE_W-1:0] turn_rate_reg;
    logic              need_deadman_reg;
    logic [DT_W-1:0]   max_tick_reg;

    logic              s1_valid_reg;
    req_t              s1_reg;
    logic              cmd_valid_reg;
    cmd_t              cmd_reg;

    logic [KEYS_N-1:0]         keys_reg;
    logic [KEYS_N-1:0]         keys_next;
    logic                      focus_reg;
    logic                      focus_next;
    logic signed [SPEED_W-1:0] lin_reg;
    logic signed [SPEED_W-1:0] lin_next;
    logic signed [SPEED_W-1:0] ang_reg;
    logic signed [SPEED_W-1:0] ang_next;

    logic                      wr_en;
    logic                      s1_tick;
    logic                      out_free;
    logic                      s1_adv;
    logic [KEYS_N-1:0]         key_mask;
    logic [DT_W-1:0]           tick;
    logic                      armed;
    logic signed [SPEED_W-1:0] tgt_lin;
    logic signed [SPEED_W-1:0] tgt_ang;
    logic [SPEED_W:0]          abs_tl;
    logic [SPEED_W:0]          abs_now;
    logic                      use_accel;
    logic [RATE_W-1:0]         lin_rate;
    logic signed [SPEED_W-1:0] lin_step;
    logic signed [SPEED_W-1:0] ang_step;
    logic signed [SPEED_W-1:0] lin_cmd;
    logic signed [SPEED_W-1:0] ang_cmd;

    // config port
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_linear_reg   <= RST_MAX_LINEAR;
            max_angular_reg  <= RST_MAX_ANGULAR;
            accel_rate_reg   <= RST_ACCEL_RATE;
            decel_rate_reg   <= RST_DECEL_RATE;
            turn_rate_reg    <= RST_TURN_RATE;
            need_deadman_reg <= RST_NEED_DEADMAN;
            max_tick_reg     <= RST_MAX_TICK;
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                REG_MAX_LINEAR:   max_linear_reg   <= pwdata[MAX_W-1:0];
                REG_MAX_ANGULAR:  max_angular_reg  <= pwdata[MAX_W-1:0];
                REG_ACCEL_RATE:   accel_rate_reg   <= pwdata[RATE_W-1:0];
                REG_DECEL_RATE:   decel_rate_reg   <= pwdata[RATE_W-1:0];
                REG_TURN_RATE:    turn_rate_reg    <= pwdata[RATE_W-1:0];
                REG_NEED_DEADMAN: need_deadman_reg <= pwdata[0];
                REG_MAX_TICK:     max_tick_reg     <= pwdata[DT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_MAX_LINEAR:   prdata = {17'd0, max_linear_reg};
            REG_MAX_ANGULAR:  prdata = {17'd0, max_angular_reg};
            REG_ACCEL_RATE:   prdata = {16'd0, accel_rate_reg};
            REG_DECEL_RATE:   prdata = {16'd0, decel_rate_reg};
            REG_TURN_RATE:    prdata = {16'd0, turn_rate_reg};
            REG_NEED_DEADMAN: prdata = {31'd0, need_deadman_reg};
            REG_MAX_TICK:     prdata = {16'd0, max_tick_reg};
            default:          prdata = '0;
        endcase
    end

    // handshake
    assign s1_tick   = (s1_reg.req_type == REQ_TICK);
    assign out_free  = !cmd_valid_reg || !cmd_stall;
    assign s1_adv    = s1_valid_reg && (!s1_tick || out_free);
    assign req_stall = s1_valid_reg && !s1_adv;
    assign cmd_valid = cmd_valid_reg;
    assign cmd_data  = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!req_stall)
        begin
            s1_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!req_stall && req_valid)
        begin
            s1_reg <= req_data;
        end
    end

    // tick datapath
    assign tick  = (s1_reg.dt_frac < max_tick_reg) ? s1_reg.dt_frac : max_tick_reg;
    assign armed = focus_reg && (!need_deadman_reg || keys_reg[KEY_DEADMAN]);

    always_comb
    begin
        tgt_lin = '0;
        tgt_ang = '0;
        if (armed)
        begin
            if (keys_reg[KEY_FWD] && !keys_reg[KEY_BACK])
            begin
                tgt_lin = {1'b0, max_linear_reg};
            end
            else if (keys_reg[KEY_BACK] && !keys_reg[KEY_FWD])
            begin
                tgt_lin = 16'(-{1'b0, max_linear_reg});
            end
            if (keys_reg[KEY_LEFT] && !keys_reg[KEY_RIGHT])
            begin
                tgt_ang = {1'b0, max_angular_reg};
            end
            else if (keys_reg[KEY_RIGHT] && !keys_reg[KEY_LEFT])
            begin
                tgt_ang = 16'(-{1'b0, max_angular_reg});
            end
        end
    end

    assign abs_tl  = tgt_lin[SPEED_W-1] ? 17'(-{tgt_lin[SPEED_W-1], tgt_lin})
                                        : {1'b0, tgt_lin};
    assign abs_now = lin_reg[SPEED_W-1] ? 17'(-{lin_reg[SPEED_W-1], lin_reg})
                                        : {1'b0, lin_reg};
    assign use_accel = (abs_tl > abs_now)
                    || (tgt_lin > 0 && lin_reg < 0)
                    || (tgt_lin < 0 && lin_reg > 0);
    assign lin_rate = use_accel ? accel_rate_reg : decel_rate_reg;

    dgvr_axis u_lin (
        .now    (lin_reg),
        .target (tgt_lin),
        .rate   (lin_rate),
        .tick   (tick),
        .lim    (max_linear_reg),
        .next   (lin_step),
        .cmd    (lin_cmd)
    );

    dgvr_axis u_ang (
        .now    (ang_reg),
        .target (tgt_ang),
        .rate   (turn_rate_reg),
        .tick   (tick),
        .lim    (max_angular_reg),
        .next   (ang_step),
        .cmd    (ang_cmd)
    );

    // state update
    assign key_mask = KEYS_N'(5'b00001 << s1_reg.key_index);

    always_comb
    begin
        keys_next  = keys_reg;
        focus_next = focus_reg;
        lin_next   = lin_reg;
        ang_next   = ang_reg;
        if (s1_adv)
        begin
            case (s1_reg.req_type)
                REQ_TICK:
                begin
                    lin_next = lin_step;
                    ang_next = ang_step;
                end
                REQ_KEY:
                begin
                    keys_next = s1_reg.level ? (keys_reg | key_mask)
                                             : (keys_reg & ~key_mask);
                end
                REQ_FOCUS:
                begin
                    focus_next = s1_reg.level;
                    keys_next  = '0;
                end
                REQ_RELEASE:
                begin
                    keys_next = '0;
                end
                default:
                begin
                    keys_next = keys_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keys_reg  <= '0;
            focus_reg <= 1'b0;
            lin_reg   <= '0;
            ang_reg   <= '0;
        end
        else
        begin
            keys_reg  <= keys_next;
            focus_reg <= focus_next;
            lin_reg   <= lin_next;
            ang_reg   <= ang_next;
        end
    end

    // command register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            cmd_valid_reg <= s1_adv && s1_tick;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_tick)
        begin
            cmd_reg.linear_cmd  <= lin_cmd;
            cmd_reg.angular_cmd <= ang_cmd;
            cmd_reg.armed       <= armed;
        end
    end

    // checks
    a_cmd_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_tick && s1_adv) |=> cmd_valid_reg)
        else $error("tick request did not load a command");

    a_cmd_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cmd_valid_reg) |-> $past(s1_valid_reg && s1_tick))
        else $error("command appeared without a tick request");

    a_focus_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && (s1_reg.req_type == REQ_FOCUS || s1_reg.req_type == REQ_RELEASE))
        |=> (keys_reg == '0))
        else $error("keys not released by focus or release request");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_reg)
            && $stable(lin_reg) && $stable(ang_reg)))
        else $error("stalled request stage changed");

endmodule

### hw/rtl/dgvr_axis.sv
// One axis of the ramp: step from rate and tick, slew toward target, clamp the command.
`timescale 1ns / 1ps

module dgvr_axis
    import dgvr_pkg::*;
(
    input  logic signed [SPEED_W-1:0] now,
    input  logic signed [SPEED_W-1:0] target,
    input  logic        [RATE_W-1:0]  rate,
    input  logic        [DT_W-1:0]    tick,
    input  logic        [MAX_W-1:0]   lim,
    output logic signed [SPEED_W-1:0] next,
    output logic signed [SPEED_W-1:0] cmd
);

    logic        [RATE_W+DT_W-1:0] prod;
    logic        [RATE_W-1:0]      step;
    logic signed [SPEED_W+1:0]     now_x;
    logic signed [SPEED_W+1:0]     delta;
    logic        [SPEED_W+1:0]     mag;
    logic        [SPEED_W+1:0]     up_val;
    logic        [SPEED_W+1:0]     dn_val;
    logic signed [SPEED_W+1:0]     next_x;
    logic signed [SPEED_W+1:0]     lim_x;

    assign prod  = rate * tick;
    assign step  = prod[RATE_W+DT_W-1:DT_W];
    assign now_x = {{2{now[SPEED_W-1]}}, now};
    assign delta = {{2{target[SPEED_W-1]}}, target} - now_x;
    assign mag   = delta[SPEED_W+1] ? 18'(-delta) : 18'(delta);
    assign up_val = now_x + {2'b00, step};
    assign dn_val = now_x - {2'b00, step};

    always_comb
    begin
        if (step == '0)
        begin
            next = now;
        end
        else if (mag <= {2'b00, step})
        begin
            next = target;
        end
        else if (delta > 0)
        begin
            next = up_val[SPEED_W-1:0];
        end
        else
        begin
            next = dn_val[SPEED_W-1:0];
        end
    end

    assign next_x = {{2{next[SPEED_W-1]}}, next};
    assign lim_x  = {3'b000, lim};

    always_comb
    begin
        if (next_x > lim_x)
        begin
            cmd = {1'b0, lim};
        end
        else if (next_x < -lim_x)
        begin
            cmd = 16'(-lim_x);
        end
        else
        begin
            cmd = next;
        end
    end

endmodule

### sim/deadman_gated_velocity_ramp_test.sv
// Testbench: randomized requests and register settings checked against a velocity ramp predictor.
`timescale 1ns / 1ps

module deadman_gated_velocity_ramp_test;
    import dgvr_pkg::*;

    localparam int IDLE_LIMIT  = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_PHASE  = 4;
    localparam int PHASES      = 8;
    localparam int DRAIN_WAIT  = 4;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_stall;
    req_t              req_data = '0;
    logic              cmd_valid;
    logic              cmd_stall = 1'b0;
    cmd_t              cmd_data;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    deadman_gated_velocity_ramp dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_data   (cmd_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor copy of registers and state
    logic [MAX_W-1:0]  cfg_max_linear   = RST_MAX_LINEAR;
    logic [MAX_W-1:0]  cfg_max_angular  = RST_MAX_ANGULAR;
    logic [RATE_W-1:0] cfg_accel_rate   = RST_ACCEL_RATE;
    logic [RATE_W-1:0] cfg_decel_rate   = RST_DECEL_RATE;
    logic [RATE_W-1:0] cfg_turn_rate    = RST_TURN_RATE;
    logic              cfg_need_deadman = RST_NEED_DEADMAN;
    logic [DT_W-1:0]   cfg_max_tick     = RST_MAX_TICK;

    logic [KEYS_N-1:0] keys_held = '0;
    logic              has_focus = 1'b0;
    int                lin_now = 0;
    int                ang_now = 0;

    req_t pending_reqs[$];
    cmd_t expected_cmds[$];
    int   queued_items = 0;

    logic failed = 1'b0;
    logic hold_request = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;
    int   stall_left = 0;
    int   rcv_calm = 0;
    int   rcv_roll;
    int   send_gap = 0;
    int   send_calm = 0;
    int   idle_cycles = 0;
    cmd_t want;

    logic [2:0] drive_keys[4] = '{KEY_FWD, KEY_BACK, KEY_LEFT, KEY_RIGHT};

    function automatic int mag(input int v);
        return v < 0 ? -v : v;
    endfunction

    function automatic int ramp_toward(input int cur, input int goal, input int step);
        int diff;
        diff = goal - cur;
        if (step <= 0)
            return cur;
        if (mag(diff) <= step)
            return goal;
        return diff > 0 ? cur + step : cur - step;
    endfunction

    function automatic int limit_mag(input int v, input int lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    task automatic advance_ramp(input req_t r);
        logic [DT_W-1:0]   tick_len;
        logic [RATE_W-1:0] lin_rate;
        logic [31:0]       lin_prod;
        logic [31:0]       ang_prod;
        logic              armed;
        logic              use_accel;
        int                lim_lin;
        int                lim_ang;
        int                tgt_lin;
        int                tgt_ang;
        cmd_t              cmd;
        case (r.req_type)
            REQ_KEY:
            begin
                if (r.key_index <= KEY_DEADMAN)
                    keys_held[r.key_index] = r.level;
            end
            REQ_FOCUS:
            begin
                has_focus = r.level;
                keys_held = '0;
            end
            REQ_RELEASE:
                keys_held = '0;
            default:
            begin
                tick_len = (r.dt_frac < cfg_max_tick) ? r.dt_frac : cfg_max_tick;
                armed = has_focus && (!cfg_need_deadman || keys_held[KEY_DEADMAN]);
                lim_lin = int'(cfg_max_linear);
                lim_ang = int'(cfg_max_angular);
                tgt_lin = 0;
                tgt_ang = 0;
                if (armed)
                begin
                    if (keys_held[KEY_FWD])   tgt_lin += lim_lin;
                    if (keys_held[KEY_BACK])  tgt_lin -= lim_lin;
                    if (keys_held[KEY_LEFT])  tgt_ang += lim_ang;
                    if (keys_held[KEY_RIGHT]) tgt_ang -= lim_ang;
                end
                use_accel = (mag(tgt_lin) > mag(lin_now)) ||
                    (tgt_lin > 0 && lin_now < 0) || (tgt_lin < 0 && lin_now > 0);
                lin_rate = use_accel ? cfg_accel_rate : cfg_decel_rate;
                lin_prod = {16'b0, lin_rate} * {16'b0, tick_len};
                ang_prod = {16'b0, cfg_turn_rate} * {16'b0, tick_len};
                lin_now = ramp_toward(lin_now, tgt_lin, int'(lin_prod >> RATE_W));
                ang_now = ramp_toward(ang_now, tgt_ang, int'(ang_prod >> RATE_W));
                cmd.linear_cmd  = SPEED_W'(limit_mag(lin_now, lim_lin));
                cmd.angular_cmd = SPEED_W'(limit_mag(ang_now, lim_ang));
                cmd.armed       = armed;
                expected_cmds.push_back(cmd);
            end
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            send_gap <= 0;
            send_calm <= 0;
        end
        else if (!req_valid || !req_stall)
        begin
            if (req_valid)
                advance_ramp(req_data);
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                req_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                req_data <= pending_reqs.pop_front();
                req_valid <= 1'b1;
                if (send_calm > 0)
                begin
                    send_calm <= send_calm - 1;
                    send_gap <= 0;
                end
                else
                begin
                    send_gap <= pick_gap();
                    if ($urandom_range(0, 39) == 0)
                        send_calm <= $urandom_range(30, 120);
                end
            end
            else
                req_valid <= 1'b0;
        end
    end

    // command monitor and stall generator
    always @(posedge clk)
    begin
        if (!rst_n)
            cmd_stall <= 1'b0;
        else
        begin
            if (cmd_valid && !cmd_stall)
            begin
                if (expected_cmds.size() == 0)
                begin
                    $error("command with none expected: linear_cmd %0d angular_cmd %0d armed %0d",
                        cmd_data.linear_cmd, cmd_data.angular_cmd, cmd_data.armed);
                    failed <= 1'b1;
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    if (cmd_data.linear_cmd !== want.linear_cmd)
                    begin
                        $error("linear_cmd mismatch: expected %0d, actual %0d",
                            want.linear_cmd, cmd_data.linear_cmd);
                        failed <= 1'b1;
                    end
                    if (cmd_data.angular_cmd !== want.angular_cmd)
                    begin
                        $error("angular_cmd mismatch: expected %0d, actual %0d",
                            want.angular_cmd, cmd_data.angular_cmd);
                        failed <= 1'b1;
                    end
                    if (cmd_data.armed !== want.armed)
                    begin
                        $error("armed mismatch: expected %0d, actual %0d",
                            want.armed, cmd_data.armed);
                        failed <= 1'b1;
                    end
                end
            end
            if (hold_request && !hold_done)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                cmd_stall <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                cmd_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                cmd_stall <= 1'b1;
            end
            else if (rcv_calm > 0)
            begin
                rcv_calm <= rcv_calm - 1;
                cmd_stall <= 1'b0;
            end
            else
            begin
                rcv_roll = $urandom_range(0, 99);
                if (rcv_roll < 60)
                    cmd_stall <= 1'b0;
                else if (rcv_roll < 90)
                begin
                    cmd_stall <= 1'b1;
                    stall_left <= $urandom_range(0, 2);
                end
                else if (rcv_roll < 97)
                begin
                    cmd_stall <= 1'b0;
                    rcv_calm <= $urandom_range(30, 120);
                end
                else
                begin
                    cmd_stall <= 1'b1;
                    stall_left <= $urandom_range(15, 50);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (cmd_valid && !cmd_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_req(input logic [1:0] kind, input logic [2:0] key, input logic lvl,
                           input logic [DT_W-1:0] dt);
        req_t r;
        r.req_type  = kind;
        r.key_index = key;
        r.level     = lvl;
        r.dt_frac   = dt;
        pending_reqs.push_back(r);
        if (!(kind == REQ_KEY && key > KEY_DEADMAN))
            queued_items++;
    endtask

    function automatic logic [2:0] rand_key();
        return 3'($urandom_range(0, 7));
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [DT_W-1:0] rand_dt();
        return DT_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [DT_W-1:0] tick_dt();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return DT_W'($urandom_range(0, 15));
            3:       return cfg_max_tick + DT_W'($urandom_range(0, 2)) - DT_W'(1);
            4:       return DT_W'($urandom_range(0, 2000));
            default: return rand_dt();
        endcase
    endfunction

    // optional focus and deadman, drive keys, a run of ticks with stray key changes, then an optional teardown
    task automatic push_session();
        int n_ticks;
        if ($urandom_range(0, 9) < 8)
            add_req(REQ_FOCUS, rand_key(), 1'b1, rand_dt());
        else if (rand_bit())
            add_req(REQ_FOCUS, rand_key(), 1'b0, rand_dt());
        if ($urandom_range(0, 9) < 8)
            add_req(REQ_KEY, KEY_DEADMAN, 1'b1, rand_dt());
        foreach (drive_keys[i])
            if (rand_bit())
                add_req(REQ_KEY, drive_keys[i], 1'b1, rand_dt());
        n_ticks = $urandom_range(1, 12);
        repeat (n_ticks)
        begin
            if ($urandom_range(0, 4) == 0)
                add_req(REQ_KEY, rand_key(), rand_bit(), rand_dt());
            add_req(REQ_TICK, rand_key(), rand_bit(), tick_dt());
        end
        case ($urandom_range(0, 2))
            0:       add_req(REQ_RELEASE, rand_key(), rand_bit(), rand_dt());
            1:       add_req(REQ_FOCUS, rand_key(), rand_bit(), rand_dt());
            default: ;
        endcase
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [DATA_W-1:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MAX_LINEAR:   cfg_max_linear = val[MAX_W-1:0];
            REG_MAX_ANGULAR:  cfg_max_angular = val[MAX_W-1:0];
            REG_ACCEL_RATE:   cfg_accel_rate = val[RATE_W-1:0];
            REG_DECEL_RATE:   cfg_decel_rate = val[RATE_W-1:0];
            REG_TURN_RATE:    cfg_turn_rate = val[RATE_W-1:0];
            REG_NEED_DEADMAN: cfg_need_deadman = val[0];
            REG_MAX_TICK:     cfg_max_tick = val[DT_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [DATA_W-1:0] pick_limit(input int hi);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DATA_W'(hi);
            2, 3, 4: return DATA_W'($urandom_range(0, hi));
            default: return DATA_W'($urandom_range(0, hi / 16));
        endcase
    endfunction

    task automatic program_limits(input int phase);
        logic [DATA_W-1:0] ml, ma, acc, dec, trn, dm, mt;
        case (phase)
            0:
            begin
                ml = 32767; ma = 32767; acc = 65535; dec = 65535; trn = 65535;
                dm = 0; mt = 65535;
            end
            1:
            begin
                // lowered maxima over a saturated state
                ml = 1000; ma = 500; acc = 300; dec = 200; trn = 400;
                dm = 1; mt = 65535;
            end
            2:
            begin
                ml = 0; ma = 0; acc = 0; dec = 0; trn = 0;
                dm = 1; mt = 0;
            end
            3:
            begin
                // tiny rates: short ticks truncate to a zero step
                ml = pick_limit(32767); ma = pick_limit(32767);
                acc = $urandom_range(1, 15); dec = $urandom_range(1, 15);
                trn = $urandom_range(1, 15);
                dm = DATA_W'(rand_bit()); mt = 65535;
            end
            default:
            begin
                ml = pick_limit(32767); ma = pick_limit(32767);
                acc = pick_limit(65535); dec = pick_limit(65535); trn = pick_limit(65535);
                dm = DATA_W'(rand_bit()); mt = pick_limit(65535);
            end
        endcase
        reg_write(REG_MAX_LINEAR, ml);
        reg_write(REG_MAX_ANGULAR, ma);
        reg_write(REG_ACCEL_RATE, acc);
        reg_write(REG_DECEL_RATE, dec);
        reg_write(REG_TURN_RATE, trn);
        reg_write(REG_NEED_DEADMAN, dm);
        reg_write(REG_MAX_TICK, mt);
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || req_valid || expected_cmds.size() != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    initial
    begin
        int target;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset settings
        add_req(REQ_TICK, KEY_FWD, 1'b0, '0);
        add_req(REQ_TICK, 3'd7, 1'b1, '1);
        add_req(REQ_KEY, 3'd5, 1'b1, '0);
        add_req(REQ_KEY, 3'd6, 1'b1, '1);
        add_req(REQ_KEY, 3'd7, 1'b1, '0);
        add_req(REQ_FOCUS, KEY_FWD, 1'b1, '0);
        add_req(REQ_KEY, KEY_FWD, 1'b1, '0);
        add_req(REQ_TICK, KEY_FWD, 1'b0, '1);
        add_req(REQ_KEY, KEY_DEADMAN, 1'b1, '1);
        add_req(REQ_TICK, KEY_FWD, 1'b0, '1);
        add_req(REQ_TICK, KEY_FWD, 1'b0, DT_W'(1));
        add_req(REQ_KEY, KEY_BACK, 1'b1, '0);
        add_req(REQ_TICK, KEY_FWD, 1'b0, RST_MAX_TICK);
        add_req(REQ_KEY, KEY_FWD, 1'b0, '0);
        add_req(REQ_TICK, KEY_FWD, 1'b0, '1);
        add_req(REQ_KEY, KEY_LEFT, 1'b1, '0);
        add_req(REQ_TICK, KEY_FWD, 1'b0, '1);
        add_req(REQ_KEY, KEY_RIGHT, 1'b1, '0);
        add_req(REQ_TICK, KEY_FWD, 1'b0, '1);
        add_req(REQ_RELEASE, 3'd7, 1'b1, '1);
        add_req(REQ_TICK, KEY_FWD, 1'b0, '1);
        add_req(REQ_FOCUS, KEY_DEADMAN, 1'b0, '1);
        add_req(REQ_TICK, KEY_DEADMAN, 1'b1, '1);
        wait_idle();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            program_limits(phase);
            if (phase == HOLD_PHASE)
                hold_request = 1'b1;
            target = queued_items + ((phase == 2) ? 100 : 210);
            while (queued_items < target)
            begin
                if ($urandom_range(0, 4) == 0)
                    add_req(2'($urandom_range(0, 3)), rand_key(), rand_bit(), rand_dt());
                else
                    push_session();
            end
            if (phase == 0)
            begin
                // leave full forward speed for the lowered maxima that follow
                add_req(REQ_FOCUS, rand_key(), 1'b1, rand_dt());
                add_req(REQ_KEY, KEY_FWD, 1'b1, rand_dt());
                add_req(REQ_TICK, rand_key(), rand_bit(), '1);
            end
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (!failed)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### files.f
hw/rtl/dgvr_pkg.sv
hw/rtl/dgvr_axis.sv
hw/rtl/deadman_gated_velocity_ramp.sv
sim/deadman_gated_velocity_ramp_test.sv
